>>> rtl/dstt_pkg.sv
package dstt_pkg;

    localparam int ENTRIES = 4;
    localparam int OUTPUTS = 8;

    localparam logic [15:0] MINUTES_IN_DAY = 16'd1440;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_INDEX = 2'd1;
    localparam logic [1:0] ERR_TIME  = 2'd2;

    localparam logic [7:0] OUTPUT_MASK = 8'((1 << OUTPUTS) - 1);

    typedef struct packed {
        logic        opcode;
        logic [10:0] minute_of_day;
        logic [7:0]  entry_index;
        logic [7:0]  entry_mask;
        logic [15:0] entry_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic [7:0] toggle_mask;
        logic [3:0] fired_entries;
        logic       day_rollover;
    } out_item_t;

    typedef struct packed {
        logic load;
    } dp_cmd_t;

    function automatic logic [10:0] reset_time(input int idx);
        logic [10:0] t;
        begin
            case (idx)
                0:       t = 11'h1a4;
                1:       t = 11'h1ab;
                2:       t = 11'h474;
                3:       t = 11'h47b;
                default: t = 11'h000;
            endcase
            return t;
        end
    endfunction

    function automatic logic [7:0] reset_mask(input int idx);
        logic [7:0] m;
        begin
            case (idx)
                0:       m = 8'd7;
                1:       m = 8'd2;
                2:       m = 8'd7;
                3:       m = 8'd2;
                default: m = 8'd0;
            endcase
            return m;
        end
    endfunction

endpackage

>>> rtl/daily_schedule_toggle_table_unit.sv
// A table of four daily schedule entries, each a minute of the day and an output toggle
// mask. A write transfer stores one entry and clears its fired flag, reporting a bad
// index or a time of 1440 or more as an error; a tick transfer carries the current
// minute, clears all fired flags when the minute goes backwards, and fires every unfired
// entry whose time matches. Every input transfer yields exactly one result transfer,
// registered and offered in the cycle after acceptance, and a new item is taken in
// every cycle while the result is not stalled, because all entries are compared in
// parallel and the result is held in an output register that frees as it is taken.
module daily_schedule_toggle_table_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dstt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dstt_pkg::out_item_t m_data
);
    import dstt_pkg::*;

    dp_cmd_t cmd;

    dstt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dstt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .item    (s_data),
        .result  (m_data)
    );

endmodule

>>> rtl/dstt_ctrl.sv
module dstt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output dstt_pkg::dp_cmd_t cmd
);
    import dstt_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_ready  = (state_reg == ST_EMPTY) || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = (state_reg == ST_FULL);
    assign cmd.load = accept;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: begin
                if (accept) begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL: begin
                if (m_ready && !accept) begin
                    state_next = ST_EMPTY;
                end
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/dstt_datapath.sv
module dstt_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  dstt_pkg::dp_cmd_t   cmd,
    input  dstt_pkg::in_item_t  item,
    output dstt_pkg::out_item_t result
);
    import dstt_pkg::*;

    logic [10:0]        time_reg [ENTRIES];
    logic [10:0]        time_next [ENTRIES];
    logic [7:0]         mask_reg [ENTRIES];
    logic [7:0]         mask_next [ENTRIES];
    logic [ENTRIES-1:0] done_reg;
    logic [ENTRIES-1:0] done_next;
    logic [10:0]        last_reg;
    logic [10:0]        last_next;
    out_item_t          result_reg;
    out_item_t          result_next;

    logic [ENTRIES-1:0] done_base;
    logic [3:0]         fired_wide;
    logic [7:0]         toggles;
    logic               rollover;
    logic               bad_index;
    logic               bad_time;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            time_next[i] = time_reg[i];
            mask_next[i] = mask_reg[i];
        end
        done_next   = done_reg;
        last_next   = last_reg;
        result_next = result_reg;
        fired_wide  = 4'd0;
        toggles     = 8'd0;
        rollover    = 1'b0;
        done_base   = done_reg;
        bad_index   = (item.entry_index >= 8'(ENTRIES));
        bad_time    = (item.entry_time >= MINUTES_IN_DAY);

        if (item.opcode == OP_WRITE) begin
            result_next.toggle_mask   = 8'd0;
            result_next.fired_entries = 4'd0;
            result_next.day_rollover  = 1'b0;
            if (bad_index) begin
                result_next.error_code = ERR_INDEX;
            end else if (bad_time) begin
                result_next.error_code = ERR_TIME;
            end else begin
                result_next.error_code = ERR_OK;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (item.entry_index == 8'(i)) begin
                        time_next[i] = item.entry_time[10:0];
                        mask_next[i] = item.entry_mask;
                        done_next[i] = 1'b0;
                    end
                end
            end
        end else begin
            rollover = (item.minute_of_day < last_reg);
            if (rollover) begin
                done_base = '0;
            end
            done_next = done_base;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!done_base[i] && (time_reg[i] == item.minute_of_day)) begin
                    toggles       = toggles ^ mask_reg[i];
                    fired_wide[i] = 1'b1;
                    done_next[i]  = 1'b1;
                end
            end
            last_next                 = item.minute_of_day;
            result_next.error_code    = ERR_OK;
            result_next.toggle_mask   = toggles & OUTPUT_MASK;
            result_next.fired_entries = fired_wide;
            result_next.day_rollover  = rollover;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                time_reg[i] <= reset_time(i);
                mask_reg[i] <= reset_mask(i);
            end
            done_reg <= '0;
            last_reg <= 11'd0;
        end else if (cmd.load) begin
            for (int i = 0; i < ENTRIES; i++) begin
                time_reg[i] <= time_next[i];
                mask_reg[i] <= mask_next[i];
            end
            done_reg <= done_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> dv/daily_schedule_toggle_table_unit_tb.sv
`timescale 1ns / 100ps

module daily_schedule_toggle_table_unit_tb;
    import dstt_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic [10:0] sched_time [ENTRIES];
    logic [7:0]  sched_mask [ENTRIES];
    logic [ENTRIES-1:0] fired_flags;
    logic [10:0] prev_minute;

    out_item_t pending_results [$];
    out_item_t want;
    int unsigned fault_count = 0;
    int unsigned stall_left = 0;
    bit quiet_phase = 1'b0;

    daily_schedule_toggle_table_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    // Advances the table state by one accepted transfer and returns its result.
    function automatic out_item_t schedule_step(input in_item_t it);
        out_item_t r;
        int k;
        r = '0;
        if (it.opcode == OP_WRITE) begin
            if (it.entry_index >= ENTRIES) begin
                r.error_code = ERR_INDEX;
            end else if (it.entry_time >= MINUTES_IN_DAY) begin
                r.error_code = ERR_TIME;
            end else begin
                r.error_code = ERR_OK;
                sched_time[it.entry_index] = it.entry_time[10:0];
                sched_mask[it.entry_index] = it.entry_mask;
                fired_flags[it.entry_index] = 1'b0;
            end
        end else begin
            r.error_code = ERR_OK;
            if (it.minute_of_day < prev_minute) begin
                fired_flags = '0;
                r.day_rollover = 1'b1;
            end
            for (k = 0; k < ENTRIES; k++) begin
                if (!fired_flags[k] && sched_time[k] == it.minute_of_day) begin
                    r.toggle_mask = r.toggle_mask ^ sched_mask[k];
                    r.fired_entries[k] = 1'b1;
                    fired_flags[k] = 1'b1;
                end
            end
            r.toggle_mask = r.toggle_mask & OUTPUT_MASK;
            prev_minute = it.minute_of_day;
        end
        return r;
    endfunction

    function automatic in_item_t noise_item();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return in_item_t'(noise[$bits(in_item_t)-1:0]);
    endfunction

    function automatic in_item_t tick_item(input logic [10:0] minute);
        in_item_t it;
        it = noise_item();
        it.opcode = OP_TICK;
        it.minute_of_day = minute;
        return it;
    endfunction

    function automatic in_item_t write_item(input logic [7:0] idx, input logic [7:0] mask,
                                            input logic [15:0] etime);
        in_item_t it;
        it = noise_item();
        it.opcode = OP_WRITE;
        it.entry_index = idx;
        it.entry_mask = mask;
        it.entry_time = etime;
        return it;
    endfunction

    task automatic send_item(input in_item_t item);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) begin
                s_data = noise_item();
                @(negedge aclk);
            end
        end
        s_valid = 1'b1;
        s_data = item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(schedule_step(item));
        @(negedge aclk);
    endtask

    task automatic note_fault(input string what, input int unsigned exp_val,
                              input int unsigned act_val);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, what, exp_val, act_val);
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            if ($urandom_range(0, 99) < 30) begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_fault("result transfer with nothing outstanding", 0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.error_code !== want.error_code) begin
                    note_fault("error_code", want.error_code, m_data.error_code);
                end
                if (m_data.toggle_mask !== want.toggle_mask) begin
                    note_fault("toggle_mask", want.toggle_mask, m_data.toggle_mask);
                end
                if (m_data.fired_entries !== want.fired_entries) begin
                    note_fault("fired_entries", want.fired_entries, m_data.fired_entries);
                end
                if (m_data.day_rollover !== want.day_rollover) begin
                    note_fault("day_rollover", want.day_rollover, m_data.day_rollover);
                end
            end
        end
    end

    task automatic test_reset_table();
        send_item(tick_item(11'h1a4));
        send_item(tick_item(11'h1ab));
        send_item(tick_item(11'h1ab));
        send_item(tick_item(11'h474));
        send_item(tick_item(11'h47b));
    endtask

    task automatic test_write_errors();
        send_item(write_item(8'd4, 8'hff, 16'd100));
        send_item(write_item(8'd255, 8'h00, 16'hffff));
        send_item(write_item(8'd0, 8'h12, 16'd1440));
        send_item(write_item(8'd3, 8'hff, 16'hffff));
        send_item(write_item(8'd0, 8'hff, 16'd0));
        send_item(write_item(8'd1, 8'h0f, 16'd0));
        send_item(write_item(8'd2, 8'h80, 16'd1439));
    endtask

    task automatic test_rollover_and_repeats();
        send_item(tick_item(11'd0));
        send_item(tick_item(11'd1439));
        send_item(tick_item(11'd1439));
        send_item(write_item(8'd2, 8'h55, 16'd1439));
        send_item(tick_item(11'd1439));
        send_item(tick_item(11'd2047));
        send_item(tick_item(11'd1439));
        send_item(tick_item(11'd0));
    endtask

    // Writes and ticks are mixed so that most ticks land on a stored time, and the
    // backward jumps that start a new day come about naturally.
    task automatic test_random_traffic(input int count);
        int n;
        int unsigned pick;
        int unsigned slot;
        logic [10:0] near;
        for (n = 0; n < count; n++) begin
            quiet_phase = (n < 100) || (n >= 400 && n < 460);
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, ENTRIES - 1);
            if (pick < 14) begin
                send_item(write_item(8'(slot), 8'($urandom),
                                     16'($urandom_range(0, 1439))));
            end else if (pick < 18) begin
                send_item(write_item(8'(slot), 8'($urandom),
                                     {5'b0, sched_time[$urandom_range(0, ENTRIES - 1)]}));
            end else if (pick < 21) begin
                send_item(write_item(8'($urandom_range(ENTRIES, 255)), 8'($urandom),
                                     16'($urandom)));
            end else if (pick < 24) begin
                send_item(write_item(8'(slot), 8'($urandom),
                                     16'($urandom_range(1440, 65535))));
            end else if (pick < 70) begin
                send_item(tick_item(sched_time[slot]));
            end else if (pick < 78) begin
                send_item(tick_item(prev_minute));
            end else if (pick < 88) begin
                send_item(tick_item(11'($urandom_range(0, 1439))));
            end else if (pick < 94) begin
                near = $urandom_range(0, 1) ? sched_time[slot] + 11'd1
                                            : sched_time[slot] - 11'd1;
                send_item(tick_item(near));
            end else begin
                send_item(tick_item(11'($urandom_range(1440, 2047))));
            end
        end
        quiet_phase = 1'b0;
    endtask

    initial begin
        sched_time[0] = 11'h1a4;
        sched_time[1] = 11'h1ab;
        sched_time[2] = 11'h474;
        sched_time[3] = 11'h47b;
        sched_mask[0] = 8'd7;
        sched_mask[1] = 8'd2;
        sched_mask[2] = 8'd7;
        sched_mask[3] = 8'd2;
        fired_flags = '0;
        prev_minute = '0;

        aresetn = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_table();
        test_write_errors();
        test_rollover_and_repeats();
        test_random_traffic(650);

        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
